// File: hdl/brsm_pkg.sv
// Package for the bytecode register stack machine: opcodes, instruction
// lengths, memory geometry and the request types passed between modules.
// No dependencies.
package brsm_pkg;

  // Register file geometry (register count is a power of two)
  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = $clog2(REG_COUNT);

  // Data memory geometry (byte count is a power of two), eight byte banks
  localparam int MEM_BYTES  = 65536;
  localparam int MEM_ADDR_W = $clog2(MEM_BYTES);
  localparam int BANKS      = 8;
  localparam int BANK_W     = $clog2(BANKS);
  localparam int ROWS       = MEM_BYTES / BANKS;
  localparam int ROW_W      = MEM_ADDR_W - BANK_W;

  localparam int WORD_W = 64;
  localparam int OUT_REG_W = 4;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [MEM_ADDR_W-1:0] maddr_t;
  typedef logic [REG_IDX_W-1:0]  ridx_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [BANK_W-1:0]     bank_t;

  // Opcodes
  typedef enum logic [7:0] {
    OP_LOADIMM = 8'd0,
    OP_ADD     = 8'd1,
    OP_SUB     = 8'd2,
    OP_XOR     = 8'd3,
    OP_PUSH    = 8'd4,
    OP_POP     = 8'd5,
    OP_JUMP    = 8'd6,
    OP_CALL    = 8'd7,
    OP_RET     = 8'd8,
    OP_LOAD    = 8'd9,
    OP_STORE   = 8'd10
  } opcode_t;

  // Instruction lengths
  localparam word_t LEN_IMM    = 64'd10;
  localparam word_t LEN_BRANCH = 64'd9;
  localparam word_t LEN_ALU    = 64'd3;
  localparam word_t LEN_STACK  = 64'd2;
  localparam word_t LEN_ONE    = 64'd1;

  // Stack slot size and reset stack pointer
  localparam word_t SLOT_BYTES = 64'd8;
  localparam word_t STACK_INIT = word_t'(MEM_BYTES) - SLOT_BYTES;

  // Data memory request: read issued at accept, write issued at execute
  typedef struct packed {
    logic   rd_en;
    maddr_t rd_addr;
    logic   wr_en;
    maddr_t wr_addr;
    word_t  wr_data;
  } mem_req_t;

  // Register file write
  typedef struct packed {
    logic  en;
    ridx_t idx;
    word_t data;
  } rf_wr_t;

endpackage

// File: hdl/bytecode_register_stack_machine.sv
// Bytecode register stack machine: executes one fetched instruction per
// input item and returns one result item per instruction. After reset the
// block clears its 64 KB data memory, one 8-byte row per cycle, and takes no
// item until the clear is done. After that it takes one item per cycle while
// the result side does not stall: an item is accepted, its register and
// memory reads go out on the same edge, it executes in the next cycle, and
// when the output register is free it writes back and its result is loaded
// into the output register; the result can be taken on the edge after that.
// Each memory bank and the register file has a single write port;
// back-to-back dependences are served by forwarding, not stalls.
module bytecode_register_stack_machine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [7:0]  first_reg_byte,
  input  logic [7:0]  second_reg_byte,
  input  logic [63:0] immediate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] next_ip,
  output logic [63:0] stack_top,
  output logic        reg_written,
  output logic [3:0]  written_reg,
  output logic [63:0] written_value,
  output logic        known_opcode
);
  import brsm_pkg::*;

  logic     accept;
  logic     fire;
  logic     clearing;
  word_t    sp;
  word_t    sp_next;
  word_t    ip;
  word_t    ip_next;
  maddr_t   addr_next;
  ridx_t    ra;
  ridx_t    rb;

  logic       s1_valid;
  logic [7:0] s1_op;
  ridx_t      s1_ra;
  word_t      s1_imm;
  maddr_t     s1_addr;
  word_t      s1_sp;

  word_t    rdata_a;
  word_t    rdata_b;
  word_t    mdata;
  word_t    val;
  logic     wr_reg;
  logic     wr_mem;
  logic     known;
  mem_req_t mreq;
  rf_wr_t   rfw;

  // Handshake: stage 1 advances when the output register is free or drains
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || fire);
  assign accept   = in_valid && in_ready;

  assign ra = first_reg_byte[REG_IDX_W-1:0];
  assign rb = second_reg_byte[REG_IDX_W-1:0];

  // Issue: stack pointer update and the one memory address of the item
  always_comb begin
    sp_next   = sp;
    addr_next = immediate[MEM_ADDR_W-1:0];
    if (opcode inside {OP_PUSH, OP_CALL}) begin
      sp_next   = sp - SLOT_BYTES;
      addr_next = sp_next[MEM_ADDR_W-1:0];
    end else if (opcode inside {OP_POP, OP_RET}) begin
      sp_next   = sp + SLOT_BYTES;
      addr_next = sp[MEM_ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= STACK_INIT;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        sp <= sp_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= opcode;
      s1_ra   <= ra;
      s1_imm  <= immediate;
      s1_addr <= addr_next;
      s1_sp   <= sp_next;
    end
  end

  // Execute: value, write targets and next instruction pointer
  always_comb begin
    val     = '0;
    wr_reg  = 1'b0;
    wr_mem  = 1'b0;
    known   = 1'b1;
    ip_next = ip + LEN_ONE;
    case (s1_op)
      OP_LOADIMM: begin
        val     = s1_imm;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_IMM;
      end
      OP_ADD: begin
        val     = rdata_a + rdata_b;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_ALU;
      end
      OP_SUB: begin
        val     = rdata_a - rdata_b;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_ALU;
      end
      OP_XOR: begin
        val     = rdata_a ^ rdata_b;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_ALU;
      end
      OP_PUSH: begin
        val     = rdata_a;
        wr_mem  = 1'b1;
        ip_next = ip + LEN_STACK;
      end
      OP_POP: begin
        val     = mdata;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_STACK;
      end
      OP_JUMP: begin
        ip_next = s1_imm;
      end
      OP_CALL: begin
        val     = ip + LEN_BRANCH;
        wr_mem  = 1'b1;
        ip_next = s1_imm;
      end
      OP_RET: begin
        ip_next = mdata;
      end
      OP_LOAD: begin
        val     = mdata;
        wr_reg  = 1'b1;
        ip_next = ip + LEN_IMM;
      end
      OP_STORE: begin
        val     = rdata_a;
        wr_mem  = 1'b1;
        ip_next = ip + LEN_IMM;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Memory and register file requests
  always_comb begin
    mreq.rd_en   = accept;
    mreq.rd_addr = addr_next;
    mreq.wr_en   = fire && wr_mem;
    mreq.wr_addr = s1_addr;
    mreq.wr_data = val;
    rfw.en       = fire && wr_reg;
    rfw.idx      = s1_ra;
    rfw.data     = val;
  end

  brsm_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_a    (ra),
    .rd_b    (rb),
    .wr      (rfw),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  brsm_datamem u_datamem (
    .clk      (clk),
    .rst      (rst),
    .req      (mreq),
    .rdata    (mdata),
    .clearing (clearing)
  );

  // Instruction pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ip        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        ip        <= ip_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_ip       <= ip_next;
      stack_top     <= s1_sp;
      reg_written   <= wr_reg;
      written_reg   <= wr_reg ? OUT_REG_W'(s1_ra) : '0;
      written_value <= val;
      known_opcode  <= known;
    end
  end

endmodule

// File: hdl/brsm_regfile.sv
// Register file of the bytecode machine: two registered read ports, one write
// port, per-entry valid bits for the zero reset and write-to-read forwarding.
// Depends on brsm_pkg.
module brsm_regfile (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  brsm_pkg::ridx_t rd_a,
  input  brsm_pkg::ridx_t rd_b,
  input  brsm_pkg::rf_wr_t wr,
  output brsm_pkg::word_t rdata_a,
  output brsm_pkg::word_t rdata_b
);
  import brsm_pkg::*;

  word_t                rf [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  word_t                rq_a;
  word_t                rq_b;
  ridx_t                ra_q;
  ridx_t                rb_q;
  logic                 lw_valid;
  ridx_t                lw_idx;
  word_t                lw_data;

  // Storage and registered reads; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (wr.en) begin
      rf[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rq_a <= valid[rd_a] ? rf[rd_a] : '0;
      rq_b <= valid[rd_b] ? rf[rd_b] : '0;
      ra_q <= rd_a;
      rb_q <= rd_b;
    end
  end

  // Valid bits and the most recent write, kept for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      lw_valid <= 1'b0;
    end else if (wr.en) begin
      valid[wr.idx] <= 1'b1;
      lw_valid      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lw_idx  <= wr.idx;
      lw_data <= wr.data;
    end
  end

  // A write on the same edge as the read is missed by the array read
  assign rdata_a = (lw_valid && lw_idx == ra_q) ? lw_data : rq_a;
  assign rdata_b = (lw_valid && lw_idx == rb_q) ? lw_data : rq_b;

endmodule

// File: hdl/brsm_datamem.sv
// Byte data memory of the bytecode machine: eight byte-wide banks so that an
// unaligned, wrapping 8-byte access touches each bank once. Holds the clearing
// pass after reset and forwarding of the latest write. Depends on brsm_pkg.
module brsm_datamem (
  input  logic              clk,
  input  logic              rst,
  input  brsm_pkg::mem_req_t req,
  output brsm_pkg::word_t   rdata,
  output logic              clearing
);
  import brsm_pkg::*;

  logic              clr_active;
  row_t              clr_row;
  row_t              wrow [BANKS];
  logic [7:0]        wbyte [BANKS];
  row_t              rrow [BANKS];
  logic [7:0]        bank_rq [BANKS];
  row_t              rd_row_q [BANKS];
  bank_t             rd_lo_q;
  logic              lw_valid;
  row_t              lw_row [BANKS];
  logic [7:0]        lw_byte [BANKS];
  logic [7:0]        fwd [BANKS];
  logic              bank_we;

  assign clearing = clr_active;
  assign bank_we  = clr_active || req.wr_en;

  // Clearing pass: one row of every bank per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_row    <= '0;
    end else if (clr_active) begin
      clr_row <= clr_row + row_t'(1);
      if (clr_row == row_t'(ROWS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Bank rows and bytes: bank b holds byte (b - base) mod 8 of the word,
  // one row further on when b lies below the base bank
  always_comb begin
    bank_t bw;
    bank_t kw;
    bank_t br;
    bw = req.wr_addr[BANK_W-1:0];
    br = req.rd_addr[BANK_W-1:0];
    for (int b = 0; b < BANKS; b++) begin
      kw = bank_t'(b) - bw;
      if (clr_active) begin
        wrow[b]  = clr_row;
        wbyte[b] = '0;
      end else begin
        wrow[b]  = req.wr_addr[MEM_ADDR_W-1:BANK_W] + row_t'(bank_t'(b) < bw);
        wbyte[b] = req.wr_data[{kw, 3'b000} +: 8];
      end
      rrow[b] = req.rd_addr[MEM_ADDR_W-1:BANK_W] + row_t'(bank_t'(b) < br);
    end
  end

  // Bank arrays
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we) begin
        mem[wrow[b]] <= wbyte[b];
      end
      if (req.rd_en) begin
        bank_rq[b]  <= mem[rrow[b]];
        rd_row_q[b] <= rrow[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_lo_q <= req.rd_addr[BANK_W-1:0];
    end
  end

  // Latest write to each bank, for a read on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (req.wr_en && !clr_active) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && !clr_active) begin
      for (int b = 0; b < BANKS; b++) begin
        lw_row[b]  <= wrow[b];
        lw_byte[b] <= wbyte[b];
      end
    end
  end

  // Forward, then rotate the banks into word order
  always_comb begin
    bank_t idx;
    for (int b = 0; b < BANKS; b++) begin
      fwd[b] = (lw_valid && lw_row[b] == rd_row_q[b]) ? lw_byte[b] : bank_rq[b];
    end
    for (int k = 0; k < BANKS; k++) begin
      idx = bank_t'(k) + rd_lo_q;
      rdata[8*k +: 8] = fwd[idx];
    end
  end

endmodule

// File: bench/brsm_exec_checker.sv
`timescale 1ns / 1ps
// Execution checker for the bytecode register stack machine: mirrors the
// machine state, predicts one result item per accepted instruction and
// compares it with the result channel. Depends on brsm_pkg.
module brsm_exec_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [7:0]  first_reg_byte,
  input  logic [7:0]  second_reg_byte,
  input  logic [63:0] immediate,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] next_ip,
  input  logic [63:0] stack_top,
  input  logic        reg_written,
  input  logic [3:0]  written_reg,
  input  logic [63:0] written_value,
  input  logic        known_opcode,
  output int          mismatches,
  output int          outstanding
);
  import brsm_pkg::*;

  typedef struct packed {
    word_t                next_ip;
    word_t                stack_top;
    logic                 reg_written;
    logic [OUT_REG_W-1:0] written_reg;
    word_t                written_value;
    logic                 known_opcode;
  } exec_result_t;

  // Shadow machine state
  word_t      regs [REG_COUNT];
  word_t      ip;
  word_t      sp;
  logic [7:0] data_mem [MEM_BYTES];

  exec_result_t expected_results [$];

  // 8-byte little-endian access, each byte address wraps on its own
  function automatic word_t mem_read(word_t addr);
    word_t  v;
    maddr_t base;
    v = '0;
    base = maddr_t'(addr);
    for (int k = 7; k >= 0; k--) v = {v[55:0], data_mem[maddr_t'(base + k)]};
    return v;
  endfunction

  function automatic void mem_write(word_t addr, word_t v);
    maddr_t base;
    base = maddr_t'(addr);
    for (int k = 0; k < 8; k++) data_mem[maddr_t'(base + k)] = v[8*k +: 8];
  endfunction

  // Execute one instruction on the shadow state, return its result item
  function automatic exec_result_t execute_instr(logic [7:0] op, logic [7:0] a_byte,
                                                 logic [7:0] b_byte, word_t imm);
    exec_result_t r;
    ridx_t        ra;
    ridx_t        rb;
    word_t        nip;
    word_t        val;
    logic         wrote;
    logic         known;
    ra = ridx_t'(a_byte);
    rb = ridx_t'(b_byte);
    nip = ip;
    val = '0;
    wrote = 1'b0;
    known = 1'b1;
    case (op)
      OP_LOADIMM: begin
        nip = ip + LEN_IMM;
        val = imm;
        regs[ra] = val;
        wrote = 1'b1;
      end
      OP_ADD, OP_SUB, OP_XOR: begin
        nip = ip + LEN_ALU;
        if (op == OP_ADD) val = regs[ra] + regs[rb];
        else if (op == OP_SUB) val = regs[ra] - regs[rb];
        else val = regs[ra] ^ regs[rb];
        regs[ra] = val;
        wrote = 1'b1;
      end
      OP_PUSH: begin
        nip = ip + LEN_STACK;
        sp = sp - SLOT_BYTES;
        val = regs[ra];
        mem_write(sp, val);
      end
      OP_POP: begin
        nip = ip + LEN_STACK;
        val = mem_read(sp);
        regs[ra] = val;
        sp = sp + SLOT_BYTES;
        wrote = 1'b1;
      end
      OP_JUMP: nip = imm;
      OP_CALL: begin
        val = ip + LEN_BRANCH;
        sp = sp - SLOT_BYTES;
        mem_write(sp, val);
        nip = imm;
      end
      OP_RET: begin
        nip = mem_read(sp);
        sp = sp + SLOT_BYTES;
      end
      OP_LOAD: begin
        nip = ip + LEN_IMM;
        val = mem_read(imm);
        regs[ra] = val;
        wrote = 1'b1;
      end
      OP_STORE: begin
        nip = ip + LEN_IMM;
        val = regs[ra];
        mem_write(imm, val);
      end
      default: begin
        nip = ip + LEN_ONE;
        known = 1'b0;
      end
    endcase
    ip = nip;
    r.next_ip = nip;
    r.stack_top = sp;
    r.reg_written = wrote;
    r.written_reg = wrote ? ra : '0;
    r.written_value = val;
    r.known_opcode = known;
    return r;
  endfunction

  // Predict on accepted instructions, compare on accepted results
  always @(posedge clk) begin : monitor
    exec_result_t got;
    exec_result_t want;
    exec_result_t pred;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) data_mem[i] = '0;
      ip = '0;
      sp = STACK_INIT;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        pred = execute_instr(opcode, first_reg_byte, second_reg_byte, immediate);
        expected_results = {expected_results, pred};
      end
      if (out_valid && out_ready) begin
        got.next_ip = next_ip;
        got.stack_top = stack_top;
        got.reg_written = reg_written;
        got.written_reg = written_reg;
        got.written_value = written_value;
        got.known_opcode = known_opcode;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result item with no instruction pending: ip=%h sp=%h",
                     $realtime, next_ip, stack_top);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch\n  expected ip=%h sp=%h wr=%b reg=%0d val=%h known=%b",
                       $realtime, want.next_ip, want.stack_top, want.reg_written,
                       want.written_reg, want.written_value, want.known_opcode);
              $display("  actual   ip=%h sp=%h wr=%b reg=%0d val=%h known=%b",
                       got.next_ip, got.stack_top, got.reg_written,
                       got.written_reg, got.written_value, got.known_opcode);
            end
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: bench/bytecode_register_stack_machine_test.sv
`timescale 1ns / 1ps
// Top of the bytecode register stack machine testbench: clock, reset,
// instruction stimulus, result back-pressure, watchdog and verdict.
// Depends on brsm_pkg, the block and brsm_exec_checker.
module bytecode_register_stack_machine_test;
  import brsm_pkg::*;

  // Opcodes outside the defined set
  localparam logic [7:0] OP_FIRST_UNKNOWN = 8'd11;
  localparam logic [7:0] OP_UNKNOWN_MID   = 8'h80;
  localparam logic [7:0] OP_LAST_UNKNOWN  = 8'hFF;

  // Covers the memory clear after reset with margin
  localparam int STALL_LIMIT = 30000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  opcode = '0;
  logic [7:0]  first_reg_byte = '0;
  logic [7:0]  second_reg_byte = '0;
  logic [63:0] immediate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] next_ip;
  logic [63:0] stack_top;
  logic        reg_written;
  logic [3:0]  written_reg;
  logic [63:0] written_value;
  logic        known_opcode;

  int          mismatches;
  int          outstanding;
  int unsigned issued = 0;
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 57;
  bit          long_hold_armed = 1'b0;
  int          stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bytecode_register_stack_machine u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .first_reg_byte  (first_reg_byte),
    .second_reg_byte (second_reg_byte),
    .immediate       (immediate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_ip         (next_ip),
    .stack_top       (stack_top),
    .reg_written     (reg_written),
    .written_reg     (written_reg),
    .written_value   (written_value),
    .known_opcode    (known_opcode)
  );

  brsm_exec_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .first_reg_byte  (first_reg_byte),
    .second_reg_byte (second_reg_byte),
    .immediate       (immediate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_ip         (next_ip),
    .stack_top       (stack_top),
    .reg_written     (reg_written),
    .written_reg     (written_reg),
    .written_value   (written_value),
    .known_opcode    (known_opcode),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Result side: random stalls, plus one long hold-off to fill the block
  initial begin : receiver
    int unsigned stretch;
    bit          hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (stretch = 0; stretch < HOLD_CYCLES; stretch++) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** bytecode_register_stack_machine: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one instruction; entered and left at a falling edge
  task automatic issue_instr(input logic [7:0] op, input logic [7:0] a_byte,
                             input logic [7:0] b_byte, input word_t imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    first_reg_byte <= a_byte;
    second_reg_byte <= b_byte;
    immediate <= imm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    @(negedge clk);
  endtask

  // Sender pause until every pending result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, 63'd0};
      3:       return word_t'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Addresses biased to places where stores and the stack land
  function automatic word_t pick_addr();
    case ($urandom_range(3))
      0:       return word_t'($urandom_range(511));
      1:       return word_t'($urandom_range(65280, 65535));
      2:       return {$urandom, $urandom};
      default: return {$urandom, 16'($urandom), 16'($urandom_range(16'hFFF8, 16'hFFFF))};
    endcase
  endfunction

  function automatic logic [7:0] pick_alu_op();
    case ($urandom_range(3))
      0:       return OP_LOADIMM;
      1:       return OP_ADD;
      2:       return OP_SUB;
      default: return OP_XOR;
    endcase
  endfunction

  // One short burst: single instructions, matched pairs with random content, some noise
  task automatic random_burst();
    int unsigned pick;
    logic [7:0]  ra;
    logic [7:0]  rb;
    word_t       addr;
    pick = $urandom_range(99);
    ra = 8'($urandom_range(255));
    rb = 8'($urandom_range(255));
    if (pick < 25) begin
      issue_instr(pick_alu_op(), ra, rb, rand_word());
    end else if (pick < 40) begin
      issue_instr(OP_PUSH, ra, rb, rand_word());
      if ($urandom_range(1)) issue_instr(pick_alu_op(), ra, rb, rand_word());
      issue_instr(OP_POP, rb, ra, rand_word());
    end else if (pick < 50) begin
      issue_instr(OP_CALL, ra, rb, rand_word());
      if ($urandom_range(1)) issue_instr(pick_alu_op(), rb, ra, rand_word());
      issue_instr(OP_RET, ra, rb, rand_word());
    end else if (pick < 65) begin
      addr = pick_addr();
      issue_instr(OP_STORE, ra, rb, addr);
      if ($urandom_range(1)) issue_instr(pick_alu_op(), ra, rb, rand_word());
      // same address, or a nearby one for a partial overlap
      if ($urandom_range(2) == 0) addr = addr + word_t'($urandom_range(7)) - 64'd3;
      issue_instr(OP_LOAD, rb, ra, addr);
    end else if (pick < 72) begin
      issue_instr(OP_JUMP, ra, rb, rand_word());
    end else if (pick < 80) begin
      issue_instr(8'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN)), ra, rb,
                  rand_word());
    end else if (pick < 90) begin
      issue_instr(8'($urandom_range(15)), ra, rb, {$urandom, $urandom});
    end else begin
      issue_instr(8'($urandom_range(255)), ra, rb, {$urandom, $urandom});
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned target;
    target = issued + count;
    while (issued < target) random_burst();
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every opcode, field extremes, stack and address wrap
    issue_instr(OP_LOADIMM, 8'h00, 8'hFF, '1);
    issue_instr(OP_LOADIMM, 8'hFF, 8'h00, 64'h8000_0000_0000_0001);
    issue_instr(OP_ADD,     8'h10, 8'hFF, '0);
    issue_instr(OP_SUB,     8'h01, 8'h00, '1);
    issue_instr(OP_XOR,     8'h0F, 8'hFF, '0);
    issue_instr(OP_PUSH,    8'hF0, 8'h00, '1);
    issue_instr(OP_POP,     8'h02, 8'h00, '0);
    // pops past the initial stack pointer reach the bottom of memory
    issue_instr(OP_POP,     8'h03, 8'h00, '0);
    issue_instr(OP_POP,     8'h04, 8'h00, '0);
    issue_instr(OP_PUSH,    8'h01, 8'h00, '0);
    issue_instr(OP_PUSH,    8'h0F, 8'h00, '0);
    // 8-byte access that wraps past the top of memory
    issue_instr(OP_STORE,   8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFC);
    issue_instr(OP_LOAD,    8'h05, 8'h00, 64'hFFFF_FFFF_FFFF_FFFC);
    issue_instr(OP_LOAD,    8'h06, 8'h00, '0);
    issue_instr(OP_STORE,   8'h8F, 8'hFF, '0);
    issue_instr(OP_CALL,    8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFA);
    issue_instr(OP_RET,     8'hFF, 8'hFF, '1);
    issue_instr(OP_JUMP,    8'h00, 8'h00, '1);
    // instruction pointer wraps past 2^64
    issue_instr(OP_LOADIMM, 8'h07, 8'h00, '0);
    issue_instr(OP_FIRST_UNKNOWN, 8'hFF, 8'hFF, '1);
    issue_instr(OP_LAST_UNKNOWN,  8'h00, 8'h00, '0);
    issue_instr(OP_UNKNOWN_MID,   8'h5A, 8'hA5, 64'h0123_4567_89AB_CDEF);
    issue_instr(OP_RET,     8'h00, 8'h00, '0);
    issue_instr(OP_JUMP,    8'h00, 8'h00, '0);
    issue_instr(OP_LOAD,    8'hAA, 8'h55, 64'h5555_5555_5555_5555);

    run_phase(370);
    drain_results();

    send_idle_pct = 57;
    recv_idle_pct = 9;
    run_phase(380);
    drain_results();

    // no idling; the receiver takes its long hold-off here
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_armed = 1'b1;
    run_phase(380);
    drain_results();
    repeat (10) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("** bytecode_register_stack_machine: PASSED **");
    else
      $display("** bytecode_register_stack_machine: FAILED **");
    $finish;
  end

endmodule
